@@ hdl/sorted_table_binary_search_top_macros.svh @@
// Assertion macros for the sorted table search block.
// Included by the top level; no other dependencies.
`ifndef SORTED_TABLE_BINARY_SEARCH_TOP_MACROS_SVH
`define SORTED_TABLE_BINARY_SEARCH_TOP_MACROS_SVH
`ifndef SYNTH
`define STBS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stbs: same-cycle check failed");
`define STBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stbs: next-cycle check failed");
`else
`define STBS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define STBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ hdl/stbs_pkg.sv @@
// Shared types and constants for the sorted table search block.
// No dependencies; imported by every module of the block but stbs_ram.
package stbs_pkg;

    localparam int unsigned TABLE_DEPTH_DEF = 256;
    localparam int unsigned VALUE_W         = 32;
    localparam int unsigned INDEX_W         = 8;
    localparam int unsigned COUNT_W         = 9;
    localparam int unsigned BOUND_W         = 10;

    typedef logic signed [BOUND_W-1:0] t_bound;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef struct packed {
        logic                      op;
        logic [INDEX_W-1:0]        entry_index;
        logic signed [VALUE_W-1:0] item_value;
    } t_in_item;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] match_index;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_PROBE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic wr;        // write the input beat into the table
        logic load;      // latch sought value, set up bounds
        logic rd_first;  // read the middle of the current range
        logic rd_next;   // take the selected half, read its middle
        logic set_hit;   // record a match at the probed index
        logic set_miss;  // record not found
        logic out_load;  // move the result into the output register
    } t_cmd;

    typedef struct packed {
        logic range_empty;  // lower bound above upper bound
        logic hit;          // probed entry equals sought value
        logic next_empty;   // the half chosen by this probe is empty
    } t_status;

endpackage

@@ hdl/sorted_table_binary_search_top.sv @@
// Sorted table search: a write beat gives no result and leaves the block idle.
// A search goes from start through P probes to done, and from done its result moves into the output register, where P
// is the number of probes (at most 9 for a 256-entry table): one table read per cycle.
// The next beat is accepted only in idle, after a search's result has moved
// into the output register; a stalled full output register holds the search in done.
// Reset (synchronous, active low) clears the entry count and control; the table is not cleared.
`include "sorted_table_binary_search_top_macros.svh"
module sorted_table_binary_search_top #(
    parameter int unsigned TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration: entry count
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [stbs_pkg::COUNT_W-1:0] i_cfg_data,
    // input beats: table writes and searches
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  stbs_pkg::t_in_item           i_in_data,
    // result beats: one per search
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output stbs_pkg::t_out_item          o_out_data
);
    import stbs_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    // The count register can always take a write; software only writes it while idle (not enforced here).
    assign o_cfg_ready = 1'b1;

    // Controller: idle accepts beats, start checks for an empty table,
    // probe compares one read entry per cycle and picks the next half,
    // done waits for the output register.
    stbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_op     (i_in_data.op),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // Datapath: table RAM, bounds, and both candidate next middles computed
    // alongside the compare so each probe's compare and next read fall in the same cycle.
    stbs_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid & o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_in_data  (i_in_data),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .o_out_data (o_out_data)
    );

    // A search keeps the input stalled on the next cycle.
    `STBS_ASSERT_NEXT(a_search_busy, i_clk, i_rst_n,
        i_in_valid && !o_in_stall && i_in_data.op == OP_SEARCH, o_in_stall)
    // After a write the input is not stalled on the next cycle.
    `STBS_ASSERT_NEXT(a_write_quick, i_clk, i_rst_n,
        i_in_valid && !o_in_stall && i_in_data.op == OP_WRITE, !o_in_stall)
    // A miss reports index zero.
    `STBS_ASSERT_IMPLY(a_miss_index, i_clk, i_rst_n,
        o_out_valid && !o_out_data.found, o_out_data.match_index == '0)
endmodule

@@ hdl/stbs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module stbs_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ hdl/stbs_dpath.sv @@
// Datapath: entry count register, search bounds, probe compare, result registers.
// Depends on stbs_pkg and stbs_ram.
module stbs_dpath #(
    parameter int unsigned TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [stbs_pkg::COUNT_W-1:0]  i_cfg_data,
    input  stbs_pkg::t_in_item            i_in_data,
    input  stbs_pkg::t_cmd                i_cmd,
    output stbs_pkg::t_status             o_status,
    output stbs_pkg::t_out_item           o_out_data
);
    import stbs_pkg::*;

    localparam int unsigned ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [COUNT_W-1:0]        r_count;
    logic signed [VALUE_W-1:0] r_value;
    t_bound                    r_lo, r_hi, r_mid;
    logic                      r_found;
    logic [INDEX_W-1:0]        r_match;
    t_out_item                 r_out;

    logic [COUNT_W-1:0]        w_count_clip;
    t_bound                    w_start_hi;
    t_bound                    w_mid_cur;
    t_bound                    w_lo_l, w_mid_l, w_hi_g, w_mid_g;
    logic                      w_empty_l, w_empty_g;
    t_bound                    w_next_lo, w_next_hi, w_next_mid, w_rd_mid;
    logic signed [VALUE_W-1:0] w_q;
    logic [VALUE_W-1:0]        w_rdata;
    logic                      w_hit, w_less;
    logic                      w_ram_we;

    // clip the count to the table size
    assign w_count_clip = (32'(r_count) > TABLE_DEPTH) ? COUNT_W'(TABLE_DEPTH) : r_count;
    assign w_start_hi   = t_bound'(w_count_clip) - t_bound'(1);

    assign w_mid_cur = r_lo + ((r_hi - r_lo) >>> 1);

    // both possible next ranges, chosen after the compare
    assign w_lo_l    = r_mid + t_bound'(1);
    assign w_mid_l   = w_lo_l + ((r_hi - w_lo_l) >>> 1);
    assign w_empty_l = w_lo_l > r_hi;
    assign w_hi_g    = r_mid - t_bound'(1);
    assign w_mid_g   = r_lo + ((w_hi_g - r_lo) >>> 1);
    assign w_empty_g = r_lo > w_hi_g;

    assign w_q    = $signed(w_rdata);
    assign w_hit  = (w_q == r_value);
    assign w_less = (w_q < r_value);

    assign w_next_lo  = w_less ? w_lo_l  : r_lo;
    assign w_next_hi  = w_less ? r_hi    : w_hi_g;
    assign w_next_mid = w_less ? w_mid_l : w_mid_g;
    assign w_rd_mid   = i_cmd.rd_first ? w_mid_cur : w_next_mid;

    assign o_status.range_empty = r_lo > r_hi;
    assign o_status.hit         = w_hit;
    assign o_status.next_empty  = w_less ? w_empty_l : w_empty_g;

    // drop writes past the end of the table
    assign w_ram_we = i_cmd.wr && (32'(i_in_data.entry_index) < TABLE_DEPTH);

    stbs_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (ADDR_W'(i_in_data.entry_index)),
        .i_wdata (i_in_data.item_value),
        .i_re    (i_cmd.rd_first | i_cmd.rd_next),
        .i_raddr (ADDR_W'($unsigned(w_rd_mid))),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg_we) begin
            r_count <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value <= i_in_data.item_value;
            r_lo    <= '0;
            r_hi    <= w_start_hi;
        end
        if (i_cmd.rd_first) begin
            r_mid <= w_mid_cur;
        end
        if (i_cmd.rd_next) begin
            r_lo  <= w_next_lo;
            r_hi  <= w_next_hi;
            r_mid <= w_next_mid;
        end
        if (i_cmd.set_hit) begin
            r_found <= 1'b1;
            r_match <= INDEX_W'($unsigned(r_mid));
        end
        if (i_cmd.set_miss) begin
            r_found <= 1'b0;
            r_match <= '0;
        end
        if (i_cmd.out_load) begin
            r_out.found       <= r_found;
            r_out.match_index <= r_match;
        end
    end

    assign o_out_data = r_out;
endmodule

@@ hdl/stbs_ctrl.sv @@
// Controller state machine: sequences table writes and search probes.
// Depends on stbs_pkg.
module stbs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_op,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  stbs_pkg::t_status i_status,
    output stbs_pkg::t_cmd    o_cmd
);
    import stbs_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if (i_in_op == OP_SEARCH) begin
                        o_cmd.load = 1'b1;
                        n_state    = S_START;
                    end else begin
                        o_cmd.wr = 1'b1;
                    end
                end
            end
            S_START: begin
                if (i_status.range_empty) begin
                    o_cmd.set_miss = 1'b1;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.rd_first = 1'b1;
                    n_state        = S_PROBE;
                end
            end
            S_PROBE: begin
                if (i_status.hit) begin
                    o_cmd.set_hit = 1'b1;
                    n_state       = S_DONE;
                end else if (i_status.next_empty) begin
                    o_cmd.set_miss = 1'b1;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.rd_next = 1'b1;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = o_cmd.out_load | (r_out_valid & i_out_stall);
    end

    assign o_out_valid = r_out_valid;
endmodule

@@ tb/tb_search_mirror_pkg.sv @@
// Shadow copy of the sorted table and its search, used by tb_top to check result beats.
// Depends on stbs_pkg for the beat types, the opcodes and the table depth.
`timescale 1ns / 100ps
package tb_search_mirror_pkg;
    import stbs_pkg::*;

    class table_search_mirror;
        logic signed [VALUE_W-1:0] entries [TABLE_DEPTH_DEF];
        logic [COUNT_W-1:0]        entry_count;
        logic [COUNT_W-1:0]        lower_bound;
        logic [COUNT_W-1:0]        upper_bound;
        t_out_item                 pending_matches [$];
        int                        mismatch_count;

        function new();
            foreach (entries[i]) entries[i] = '0;
            entry_count    = '0;
            lower_bound    = '0;
            upper_bound    = '0;
            mismatch_count = 0;
        endfunction

        function void set_count(logic [COUNT_W-1:0] count);
            entry_count = count;
        endfunction

        function logic signed [VALUE_W-1:0] entry_at(int idx);
            return entries[idx];
        endfunction

        function int pending();
            return pending_matches.size();
        endfunction

        // Halving probe over the used entries; stop at the first equal entry.
        function t_out_item search_table(logic signed [VALUE_W-1:0] sought);
            int        lo;
            int        hi;
            int        mid;
            int        span;
            t_out_item res;
            span = (entry_count > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : int'(entry_count);
            lo   = 0;
            hi   = span - 1;
            res  = '0;
            while (lo <= hi) begin
                mid = lo + (hi - lo) / 2;
                if (entries[mid] == sought) begin
                    res.found       = 1'b1;
                    res.match_index = mid[INDEX_W-1:0];
                    break;
                end else if (entries[mid] < sought) begin
                    lo = mid + 1;
                end else begin
                    hi = mid - 1;
                end
            end
            lower_bound = lo[COUNT_W-1:0];
            upper_bound = hi[COUNT_W-1:0];
            return res;
        endfunction

        // Apply an accepted input beat: store a write, queue the outcome of a search.
        function void note_beat(t_in_item beat);
            if (beat.op == OP_WRITE) begin
                entries[beat.entry_index] = beat.item_value;
            end else begin
                pending_matches.push_back(search_table(beat.item_value));
            end
        endfunction

        // Compare an accepted result beat with the oldest outstanding search.
        function void check_match(t_out_item got);
            t_out_item want;
            if (pending_matches.size() == 0) begin
                $display("%0t: result beat with no search outstanding: found %0b index %0d",
                         $time, got.found, got.match_index);
                mismatch_count++;
                return;
            end
            want = pending_matches.pop_front();
            if (got.found !== want.found) begin
                $display("%0t: found mismatch: expected %0b, actual %0b",
                         $time, want.found, got.found);
                mismatch_count++;
            end
            if (got.match_index !== want.match_index) begin
                $display("%0t: match_index mismatch: expected %0d, actual %0d",
                         $time, want.match_index, got.match_index);
                mismatch_count++;
            end
        endfunction
    endclass

endpackage

@@ tb/tb_top.sv @@
// Self-checking bench for sorted_table_binary_search_top: directed and random table
// writes and searches, checked against tb_search_mirror_pkg; needs stbs_pkg and the RTL.
`timescale 1ns / 100ps
module tb_top;
    import stbs_pkg::*;
    import tb_search_mirror_pkg::*;

    localparam int ITEM_GOAL      = 950;
    // Tail wait covers a search of up to 9 probes; leave a margin for a trailing write.
    localparam int TAIL_CYCLES    = 16;
    localparam int LONG_HOLD      = 300;
    localparam int HOLD_AT_RESULT = 20;

    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [COUNT_W-1:0] cfg_data;
    logic               in_valid;
    logic               in_stall;
    t_in_item           in_data;
    logic               out_valid;
    logic               out_stall;
    t_out_item          out_data;

    table_search_mirror mirror;
    int                 beats_sent;
    int                 results_taken;
    // While set, both sides run back to back with no idle cycles.
    bit                 calm;
    bit                 long_hold_done;

    sorted_table_binary_search_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop, far beyond the slowest passing run.
    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Present one input beat after a random gap and hold it until accepted.
    // With no gap, valid stays high and only the payload moves on.
    task automatic send_beat(t_in_item beat);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            @(negedge clk) in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= beat;
        do @(posedge clk); while (in_stall);
        mirror.note_beat(beat);
        beats_sent++;
    endtask

    task automatic send_write(int idx, logic signed [VALUE_W-1:0] value);
        t_in_item beat;
        beat.op          = OP_WRITE;
        beat.entry_index = idx[INDEX_W-1:0];
        beat.item_value  = value;
        send_beat(beat);
    endtask

    task automatic send_search(logic signed [VALUE_W-1:0] value);
        t_in_item beat;
        beat.op          = OP_SEARCH;
        beat.entry_index = $urandom_range(0, 255);
        beat.item_value  = value;
        send_beat(beat);
    endtask

    // Drop valid, wait for every outstanding result, then let in-flight writes settle.
    task automatic drain();
        @(negedge clk) in_valid <= 1'b0;
        while (mirror.pending() != 0) @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    // Write the entry count only while the block is idle.
    task automatic write_count(logic [COUNT_W-1:0] count);
        drain();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= count;
        do @(posedge clk); while (!cfg_ready);
        mirror.set_count(count);
        @(negedge clk) cfg_valid <= 1'b0;
    endtask

    // Fill entries 0..n-1 in ascending order: dense runs give duplicates,
    // sparse runs spread from the bottom of the range, clamped at the top.
    task automatic fill_sorted(int n, bit dense);
        longint v;
        longint step_max;
        step_max = 64'sd4294967295 / n;
        v = dense ? longint'($signed($urandom)) : -64'sd2147483648 + $urandom_range(0, 1000);
        for (int i = 0; i < n; i++) begin
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            send_write(i, v[VALUE_W-1:0]);
            v += dense ? $urandom_range(0, 2) : $urandom_range(0, step_max[31:0]);
        end
    endtask

    // Mostly stored values (hits), some near misses, the rest anywhere.
    function automatic logic signed [VALUE_W-1:0] pick_sought(int span);
        int                        roll;
        logic signed [VALUE_W-1:0] v;
        roll = $urandom_range(0, 99);
        if (span == 0 || roll >= 72) return $urandom;
        v = mirror.entry_at($urandom_range(0, span - 1));
        if (roll >= 55) v = ($urandom_range(0, 1) != 0) ? v + 1 : v - 1;
        return v;
    endfunction

    task automatic run_searches(int n);
        int span;
        span = (mirror.entry_count > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF
                                                      : int'(mirror.entry_count);
        for (int k = 0; k < n; k++) begin
            // Stray writes break the order now and then; the probe runs regardless.
            if ($urandom_range(0, 99) < 8) send_write($urandom_range(0, 255), $urandom);
            else send_search(pick_sought(span));
        end
    endtask

    // Result side: random stall before each beat, one long hold-off early on.
    initial begin
        int hold;
        out_stall = 1'b1;
        wait (rst_n === 1'b1);
        forever begin
            hold = calm ? 0 : $urandom_range(0, 11);
            if (!long_hold_done && results_taken >= HOLD_AT_RESULT) begin
                hold           = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            if (hold > 0) begin
                @(negedge clk) out_stall <= 1'b1;
                repeat (hold - 1) @(negedge clk);
            end
            @(negedge clk) out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            mirror.check_match(out_data);
            results_taken++;
        end
    end

    initial begin
        int count;
        int pick;
        mirror         = new();
        beats_sent     = 0;
        results_taken  = 0;
        calm           = 1'b0;
        long_hold_done = 1'b0;
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        in_data        = '0;
        repeat (9) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // Empty table: nothing to probe, never found.
        write_count(0);
        send_search(0);
        send_search(VAL_MIN);

        // One entry: hit, miss above, and the upper bound falling below index zero.
        send_write(255, VAL_MAX);
        send_write(0, 100);
        write_count(1);
        send_search(50);
        send_search(100);
        send_search(200);
        send_write(0, VAL_MIN);
        send_search(VAL_MIN);
        send_search(VAL_MAX);
        send_write(0, VAL_MAX);
        send_search(VAL_MAX);
        send_search(VAL_MIN);

        // Full table with the value extremes at both ends; from here on
        // every entry has been written. The long hold-off falls in these searches.
        write_count(256);
        fill_sorted(256, 1'b0);
        send_write(0, VAL_MIN);
        send_write(255, VAL_MAX);
        run_searches(40);

        // Counts above the table depth clamp to the full table.
        write_count(511);
        run_searches(15);

        while (beats_sent < ITEM_GOAL) begin
            pick = $urandom_range(0, 9);
            case (pick)
                0: count = 0;
                1: count = 1;
                2: count = $urandom_range(2, 3);
                3: count = 256;
                4: count = $urandom_range(257, 511);
                default: count = $urandom_range(2, 40);
            endcase
            calm = ($urandom_range(0, 4) == 0);
            write_count(count[COUNT_W-1:0]);
            if (count >= 1 && count <= 48) fill_sorted(count, $urandom_range(0, 1));
            run_searches($urandom_range(10, 40));
        end

        drain();
        if (mirror.mismatch_count == 0 && mirror.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
